/* src/distance_vector_route_engine_unit_defines.svh */
// ---------------------------------------------------------------------------
// Distance-vector route engine assertion macros
// Concurrent check helpers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_ENGINE_UNIT_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define DVRE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dvre assertion failed");
`define DVRE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) \
		else $error("dvre assertion failed");
`else
`define DVRE_ASSERT(label, clk, rst_n, prop)
`define DVRE_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

/* src/dvre_pkg.sv */
// ---------------------------------------------------------------------------
// Distance-vector route engine package
// Shared constants, types and address helpers.
// ---------------------------------------------------------------------------
`default_nettype none
package dvre_pkg;
	localparam int MAX_NODES = 16;
	localparam int ROW_LIMIT = 16;
	localparam int N_CAP = (MAX_NODES < ROW_LIMIT) ? MAX_NODES : ROW_LIMIT;
	localparam int COST_W = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
	localparam int MAT_AW = $clog2(MAT_DEPTH);
	localparam logic [COST_W-1:0] INF_COST = COST_W'(65535);

	localparam logic [1:0] CMD_SET_NODE = 2'd0;
	localparam logic [1:0] CMD_WRITE_CELL = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;
	localparam logic [1:0] CMD_RUN = 2'd3;

	localparam logic CFG_LOCAL_INDEX = 1'b0;
	localparam logic CFG_NODE_COUNT = 1'b1;

	typedef struct packed {
		logic [COST_W-1:0] next_cost;
		logic              better;
	} relax_res_t;

	function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		mat_addr = MAT_AW'(MAT_AW'(r) * MAT_AW'(MAX_NODES) + MAT_AW'(c));
	endfunction
endpackage
`default_nettype wire

/* src/dvre_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module dvre_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* src/dvre_relax_alu.sv */
// ---------------------------------------------------------------------------
// Relaxation step
// Saturating path sum, compare against current cost and clamp to INF.
// ---------------------------------------------------------------------------
`default_nettype none
module dvre_relax_alu (
	input  wire logic [dvre_pkg::COST_W-1:0] via_a,
	input  wire logic [dvre_pkg::COST_W-1:0] via_b,
	input  wire logic [dvre_pkg::COST_W-1:0] cur,
	output dvre_pkg::relax_res_t             res
);
	logic [dvre_pkg::COST_W:0]   sum_w;
	logic [dvre_pkg::COST_W-1:0] sat_w;
	logic [dvre_pkg::COST_W-1:0] pick_w;

	always_comb begin
		sum_w = {1'b0, via_a} + {1'b0, via_b};
		sat_w = (sum_w > {1'b0, dvre_pkg::INF_COST}) ? dvre_pkg::INF_COST
			: sum_w[dvre_pkg::COST_W-1:0];
		res.better = cur > sat_w;
		pick_w = res.better ? sat_w : cur;
		res.next_cost = (pick_w > dvre_pkg::INF_COST) ? dvre_pkg::INF_COST : pick_w;
	end
endmodule
`default_nettype wire

/* src/distance_vector_route_engine_unit.sv */
// ---------------------------------------------------------------------------
// Distance-vector route engine
// Cost matrix, node table and next hops with Bellman-Ford relaxation.
// ---------------------------------------------------------------------------
// Requests enter on s_tvalid/s_tready/s_tdata with the command in s_tuser.
// Set-node and cell-write requests write in the execute state. An update
// request scans the node table and on a match updates the matrix. A run
// request relaxes the matrix in passes over the n active nodes until a
// pass changes nothing; each k step is one read of both matrix copies and
// the node table, so the matrix read port sets the rate. If local_index is
// below n, the local row then leaves on m_tvalid/m_tready/m_tdata, m_tlast
// on the final entry. One request is in flight at a time; s_tready is low
// until it is done. A stall on m_tready holds the current entry and the
// engine waits. Reset clears control state and sets local_index 0,
// node_count 16; the memories hold no defined data until loaded. cfg_we
// writes register cfg_index (0 local_index, 1 node_count) from cfg_data;
// the user must do so only while idle, as the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "distance_vector_route_engine_unit_defines.svh"
module distance_vector_route_engine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// row_index[3:0], col_index[7:4], node_id[23:8], cost[39:24], next_hop[55:40]
	input  wire logic [55:0] s_tdata,
	// command[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// node_index[3:0], route_cost[19:4], hop_id[35:20], zero[39:36]
	output logic      [39:0] m_tdata,
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data
);
	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_EXEC  = 15'b000000000000010,
		ST_SRD   = 15'b000000000000100,
		ST_SCHK  = 15'b000000000001000,
		ST_URD   = 15'b000000000010000,
		ST_UPOI  = 15'b000000000100000,
		ST_UWR   = 15'b000000001000000,
		ST_CRD   = 15'b000000010000000,
		ST_CLD   = 15'b000000100000000,
		ST_KRD   = 15'b000001000000000,
		ST_KCMP  = 15'b000010000000000,
		ST_RWB   = 15'b000100000000000,
		ST_ERD   = 15'b001000000000000,
		ST_ELD   = 15'b010000000000000,
		ST_EWAIT = 15'b100000000000000
	} state_t;

	localparam int CW = dvre_pkg::COST_W;
	localparam int IW = dvre_pkg::IDX_W;
	localparam int NW = dvre_pkg::CNT_W;

	state_t         state_q;
	logic [1:0]     cmd_q;
	logic [IW-1:0]  row_q, col_q, local_q, i_q, j_q, k_q;
	logic [CW-1:0]  id_q, cost_q, hop_q, cur_q, nh_q;
	logic [NW-1:0]  count_q, n_w;
	logic           changed_q, nh_upd_q, m_tvalid_q, m_tlast_q;
	logic [39:0]    m_tdata_q;

	logic                         mat_we;
	logic [dvre_pkg::MAT_AW-1:0]  mat_waddr, mat_raddr_a, mat_raddr_b;
	logic [CW-1:0]                mat_wdata, mat_rd_a, mat_rd_b;
	logic                         node_we, hop_we;
	logic [dvre_pkg::NODE_AW-1:0] node_waddr, hop_waddr, node_raddr, hop_raddr;
	logic [CW-1:0]                hop_wdata, node_rd, hop_rd;
	logic [CW-1:0]                via_a_w, via_b_w;
	dvre_pkg::relax_res_t         alu_res;
	logic                         k_last, j_last, i_last, row_ok, local_ok, poison_w;

	always_comb begin
		n_w = (32'(count_q) > dvre_pkg::N_CAP) ? NW'(dvre_pkg::N_CAP) : count_q;
		k_last = (NW'(k_q) + NW'(1)) == n_w;
		j_last = (NW'(j_q) + NW'(1)) == n_w;
		i_last = (NW'(i_q) + NW'(1)) == n_w;
		row_ok = 32'(row_q) < dvre_pkg::MAX_NODES;
		local_ok = 32'(local_q) < dvre_pkg::MAX_NODES;
		poison_w = (mat_rd_a < cost_q) && (hop_rd == node_rd);
		via_a_w = (k_q == j_q) ? cur_q : mat_rd_a;
		via_b_w = (k_q == i_q) ? cur_q : mat_rd_b;
	end

	dvre_relax_alu u_alu (
		.via_a(via_a_w),
		.via_b(via_b_w),
		.cur  (cur_q),
		.res  (alu_res)
	);

	always_comb begin
		mat_raddr_a = dvre_pkg::mat_addr(i_q, j_q);
		mat_raddr_b = dvre_pkg::mat_addr(k_q, j_q);
		node_raddr = dvre_pkg::NODE_AW'(k_q);
		hop_raddr = dvre_pkg::NODE_AW'(k_q);
		if (state_q == ST_URD) begin
			mat_raddr_a = dvre_pkg::mat_addr(row_q, k_q);
			node_raddr = dvre_pkg::NODE_AW'(row_q);
		end else if (state_q == ST_KRD) begin
			mat_raddr_a = dvre_pkg::mat_addr(i_q, k_q);
		end else if (state_q == ST_ERD) begin
			mat_raddr_a = dvre_pkg::mat_addr(local_q, j_q);
			hop_raddr = dvre_pkg::NODE_AW'(j_q);
		end
	end

	always_comb begin
		mat_we = 1'b0;
		mat_waddr = dvre_pkg::mat_addr(row_q, col_q);
		mat_wdata = cost_q;
		node_we = 1'b0;
		node_waddr = dvre_pkg::NODE_AW'(row_q);
		hop_we = 1'b0;
		hop_waddr = dvre_pkg::NODE_AW'(row_q);
		hop_wdata = hop_q;
		unique case (state_q)
			ST_EXEC: begin
				if (cmd_q == dvre_pkg::CMD_SET_NODE) begin
					node_we = row_ok;
					hop_we = row_ok;
				end else if (cmd_q == dvre_pkg::CMD_WRITE_CELL) begin
					mat_we = row_ok && (32'(col_q) < dvre_pkg::MAX_NODES);
				end
			end
			ST_UPOI: begin
				mat_we = poison_w && local_ok;
				mat_waddr = dvre_pkg::mat_addr(local_q, k_q);
				mat_wdata = dvre_pkg::INF_COST;
				hop_we = poison_w;
				hop_waddr = dvre_pkg::NODE_AW'(k_q);
				hop_wdata = dvre_pkg::INF_COST;
			end
			ST_UWR: begin
				mat_we = 1'b1;
				mat_waddr = dvre_pkg::mat_addr(row_q, k_q);
			end
			ST_RWB: begin
				mat_we = 1'b1;
				mat_waddr = dvre_pkg::mat_addr(i_q, j_q);
				mat_wdata = cur_q;
				hop_we = nh_upd_q;
				hop_waddr = dvre_pkg::NODE_AW'(j_q);
				hop_wdata = nh_q;
			end
			default: begin
			end
		endcase
	end

	dvre_ram #(.WIDTH(CW), .DEPTH(dvre_pkg::MAT_DEPTH)) u_mat_a (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
		.raddr(mat_raddr_a), .rdata(mat_rd_a)
	);
	dvre_ram #(.WIDTH(CW), .DEPTH(dvre_pkg::MAT_DEPTH)) u_mat_b (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
		.raddr(mat_raddr_b), .rdata(mat_rd_b)
	);
	dvre_ram #(.WIDTH(CW), .DEPTH(dvre_pkg::MAX_NODES)) u_node (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(id_q),
		.raddr(node_raddr), .rdata(node_rd)
	);
	dvre_ram #(.WIDTH(CW), .DEPTH(dvre_pkg::MAX_NODES)) u_hop (
		.clk(clk), .we(hop_we), .waddr(hop_waddr), .wdata(hop_wdata),
		.raddr(hop_raddr), .rdata(hop_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= '0;
			count_q <= NW'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				dvre_pkg::CFG_LOCAL_INDEX: local_q <= cfg_data[IW-1:0];
				dvre_pkg::CFG_NODE_COUNT:  count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q <= s_tuser;
			row_q <= s_tdata[3:0];
			col_q <= s_tdata[7:4];
			id_q <= s_tdata[23:8];
			cost_q <= s_tdata[39:24];
			hop_q <= s_tdata[55:40];
		end
		if (state_q == ST_CLD) begin
			cur_q <= mat_rd_a;
		end else if (state_q == ST_KCMP) begin
			cur_q <= alu_res.next_cost;
		end
		if (state_q == ST_KCMP && alu_res.better && i_q == local_q) begin
			nh_q <= node_rd;
		end
		if (state_q == ST_ELD) begin
			m_tdata_q <= {4'd0, hop_rd, mat_rd_a, j_q};
			m_tlast_q <= j_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			changed_q <= 1'b0;
			nh_upd_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
					changed_q <= 1'b0;
					state_q <= ST_IDLE;
					if (cmd_q == dvre_pkg::CMD_UPDATE && row_ok && n_w != '0) begin
						state_q <= ST_SRD;
					end else if (cmd_q == dvre_pkg::CMD_RUN && n_w != '0) begin
						state_q <= ST_CRD;
					end
				end
				ST_SRD: state_q <= ST_SCHK;
				ST_SCHK: begin
					if (node_rd == id_q) begin
						state_q <= ST_URD;
					end else if (k_last) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + IW'(1);
						state_q <= ST_SRD;
					end
				end
				ST_URD:  state_q <= ST_UPOI;
				ST_UPOI: state_q <= ST_UWR;
				ST_UWR:  state_q <= ST_IDLE;
				ST_CRD:  state_q <= ST_CLD;
				ST_CLD: begin
					k_q <= '0;
					nh_upd_q <= 1'b0;
					state_q <= ST_KRD;
				end
				ST_KRD: state_q <= ST_KCMP;
				ST_KCMP: begin
					if (alu_res.better) begin
						changed_q <= 1'b1;
						if (i_q == local_q) begin
							nh_upd_q <= 1'b1;
						end
					end
					if (k_last) begin
						state_q <= ST_RWB;
					end else begin
						k_q <= k_q + IW'(1);
						state_q <= ST_KRD;
					end
				end
				ST_RWB: begin
					state_q <= ST_CRD;
					if (!j_last) begin
						j_q <= j_q + IW'(1);
					end else begin
						j_q <= '0;
						if (!i_last) begin
							i_q <= i_q + IW'(1);
						end else begin
							i_q <= '0;
							changed_q <= 1'b0;
							if (!changed_q) begin
								state_q <= (NW'(local_q) < n_w) ? ST_ERD : ST_IDLE;
							end
						end
					end
				end
				ST_ERD: state_q <= ST_ELD;
				ST_ELD: begin
					m_tvalid_q <= 1'b1;
					state_q <= ST_EWAIT;
				end
				ST_EWAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (j_last) begin
							state_q <= ST_IDLE;
						end else begin
							j_q <= j_q + IW'(1);
							state_q <= ST_ERD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

	`DVRE_ASSERT(a_out_only_emit, clk, arst_n, m_tvalid_q |-> (state_q == ST_EWAIT))
	`DVRE_ASSERT_NEXT(a_accept_busy, clk, arst_n, s_tvalid && s_tready, state_q != ST_IDLE)
	`DVRE_ASSERT(a_k_in_range, clk, arst_n, (state_q == ST_KRD) |-> (NW'(k_q) < n_w))
	`DVRE_ASSERT(a_local_in_emit, clk, arst_n, (state_q == ST_ERD) |-> (NW'(local_q) < n_w))
endmodule
`default_nettype wire
